/* hdl/plis_pkg.sv */
`default_nettype none

package plis_pkg;

  localparam int LIST_CAPACITY_DEF = 16;
  localparam int VALUE_WIDTH_DEF   = 32;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Source a cell loads from in a cycle
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_HEAD
  } cell_sel_t;

endpackage

`default_nettype wire

/* hdl/positional_list_insert_delete.sv */
`default_nettype none

// Ordered list of up to LIST_CAPACITY words, addressed by 1-based position.
// Each input word is a request on in_tuser: insert at position, delete at
// position, or dump. Insert and delete return one result word and finish in
// the cycle they are accepted, so they run at one word per cycle while the
// result side keeps taking words. A dump of n entries returns n result words
// (tlast on the final one); in_tready stays low while they stream out, one
// entry per cycle while the result side takes them, as the row of cells
// rotates its first n entries toward cell 0. A dump of an empty list returns
// a single word with status empty. Bad positions and inserts into a full list
// return an error status and leave the list as it was. Stored values keep the
// low VALUE_WIDTH bits of new_value; out_value is the stored value
// zero-extended or cut to 32 bits. length_after carries the low 5 bits of the
// count.
module positional_list_insert_delete #(
  parameter int LIST_CAPACITY = plis_pkg::LIST_CAPACITY_DEF,
  parameter int VALUE_WIDTH   = plis_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [4:0] position, [36:5] new_value, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] out_value, [36:32] length_after, rest zero
  output logic             out_tlast,  // is_last
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int LEN_W = $clog2(LIST_CAPACITY + 1);
  localparam int CMP_W = ((LEN_W > 5) ? LEN_W : 5) + 1;

  // Unpack the request word
  logic [4:0]             in_pos;
  logic [31:0]            in_value;
  logic [VALUE_WIDTH+31:0] in_value_ext;
  logic [VALUE_WIDTH-1:0] new_val;
  plis_pkg::req_t         in_req;

  assign in_pos       = in_tdata[4:0];
  assign in_value     = in_tdata[36:5];
  assign in_value_ext = {{VALUE_WIDTH{1'b0}}, in_value};
  assign new_val      = in_value_ext[VALUE_WIDTH-1:0];
  assign in_req       = plis_pkg::req_t'(in_tuser);

  // Control state
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;
  plis_pkg::status_t     out_status_r, out_status_nxt;
  logic [4:0]            out_len_r, out_len_nxt;

  // Cell row
  logic [VALUE_WIDTH-1:0] cell_val [LIST_CAPACITY];
  plis_pkg::cell_sel_t    cell_sel [LIST_CAPACITY];
  logic [VALUE_WIDTH+31:0] head_ext;

  logic out_free;
  logic in_acc;
  logic ins_go, del_go, rot_go;
  logic [CMP_W-1:0] pos_w, len_w, slot_w, cnt_w, len_nxt_w;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !busy_r && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign pos_w     = CMP_W'(in_pos);
  assign len_w     = CMP_W'(len_r);
  assign slot_w    = pos_w - CMP_W'(1);
  assign cnt_w     = CMP_W'(cnt_r);
  assign len_nxt_w = CMP_W'(len_nxt);
  assign head_ext  = {32'b0, cell_val[0]};

  always_comb begin
    len_nxt        = len_r;
    busy_nxt       = busy_r;
    cnt_nxt        = cnt_r;
    ins_go         = 1'b0;
    del_go         = 1'b0;
    rot_go         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;

    if (in_acc) begin
      case (in_req)
        plis_pkg::REQ_INSERT: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = 32'b0;
          out_last_nxt  = 1'b1;
          if (pos_w == CMP_W'(0) || pos_w > len_w + CMP_W'(1)) begin
            out_status_nxt = plis_pkg::ST_RANGE;
          end else if (len_w == CMP_W'(LIST_CAPACITY)) begin
            out_status_nxt = plis_pkg::ST_FULL;
          end else begin
            out_status_nxt = plis_pkg::ST_OK;
            ins_go         = 1'b1;
            len_nxt        = len_r + LEN_W'(1);
          end
        end
        plis_pkg::REQ_DELETE: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = 32'b0;
          out_last_nxt  = 1'b1;
          if (len_r == LEN_W'(0)) begin
            out_status_nxt = plis_pkg::ST_EMPTY;
          end else if (pos_w == CMP_W'(0) || pos_w > len_w) begin
            out_status_nxt = plis_pkg::ST_RANGE;
          end else begin
            out_status_nxt = plis_pkg::ST_OK;
            del_go         = 1'b1;
            len_nxt        = len_r - LEN_W'(1);
          end
        end
        plis_pkg::REQ_DUMP: begin
          if (len_r == LEN_W'(0)) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = 32'b0;
            out_last_nxt   = 1'b1;
            out_status_nxt = plis_pkg::ST_EMPTY;
          end else begin
            // mark busy; entries stream out once busy is registered and the result side is free
            busy_nxt = 1'b1;
            cnt_nxt  = LEN_W'(0);
          end
        end
        default: begin
          // unknown kind: drop the word
        end
      endcase
      out_len_nxt = len_nxt_w[4:0];
    end else if (busy_r && out_free) begin
      // emit cell 0 and rotate the occupied cells by one
      rot_go         = 1'b1;
      out_valid_nxt  = 1'b1;
      out_value_nxt  = head_ext[31:0];
      out_last_nxt   = (cnt_w + CMP_W'(1) == len_w);
      out_status_nxt = plis_pkg::ST_OK;
      out_len_nxt    = len_w[4:0];
      cnt_nxt        = cnt_r + LEN_W'(1);
      if (cnt_w + CMP_W'(1) == len_w) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Per-cell load select
  always_comb begin
    for (int i = 0; i < LIST_CAPACITY; i++) begin
      cell_sel[i] = plis_pkg::SEL_HOLD;
      if (ins_go) begin
        if (CMP_W'(i) == slot_w) begin
          cell_sel[i] = plis_pkg::SEL_NEW;
        end else if (CMP_W'(i) > slot_w && CMP_W'(i) <= len_w) begin
          cell_sel[i] = plis_pkg::SEL_LEFT;
        end
      end else if (del_go) begin
        if (CMP_W'(i) >= slot_w && CMP_W'(i) + CMP_W'(1) < len_w) begin
          cell_sel[i] = plis_pkg::SEL_RIGHT;
        end
      end else if (rot_go) begin
        if (CMP_W'(i) + CMP_W'(1) < len_w) begin
          cell_sel[i] = plis_pkg::SEL_RIGHT;
        end else if (CMP_W'(i) + CMP_W'(1) == len_w) begin
          cell_sel[i] = plis_pkg::SEL_HEAD;
        end
      end
    end
  end

  for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == LIST_CAPACITY - 1) ? g : g + 1;
    plis_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .sel       (cell_sel[g]),
      .new_val   (new_val),
      .left_val  (cell_val[L]),
      .right_val (cell_val[R]),
      .head_val  (cell_val[0]),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_len_r, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

/* hdl/plis_cell.sv */
`default_nettype none

module plis_cell #(
  parameter int VALUE_WIDTH = plis_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire plis_pkg::cell_sel_t    sel,
  input  wire logic [VALUE_WIDTH-1:0] new_val,
  input  wire logic [VALUE_WIDTH-1:0] left_val,
  input  wire logic [VALUE_WIDTH-1:0] right_val,
  input  wire logic [VALUE_WIDTH-1:0] head_val,
  output logic      [VALUE_WIDTH-1:0] val
);

  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] val_nxt;

  always_comb begin
    case (sel)
      plis_pkg::SEL_NEW:   val_nxt = new_val;
      plis_pkg::SEL_LEFT:  val_nxt = left_val;
      plis_pkg::SEL_RIGHT: val_nxt = right_val;
      plis_pkg::SEL_HEAD:  val_nxt = head_val;
      default:             val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

/* hdl/plis_checker.sv */
`default_nettype none

module plis_checker #(
  parameter int LIST_CAPACITY = plis_pkg::LIST_CAPACITY_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  localparam logic [4:0] CAP_LO = 5'(LIST_CAPACITY);

  // Only dump entries come without tlast, and they are always ok
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == plis_pkg::ST_OK)
    else $error("non-final result with error status");

  // Full status only when the count sits at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == plis_pkg::ST_FULL |-> out_tdata[36:32] == CAP_LO)
    else $error("full status with count below capacity");

  // Empty status carries zero count and zero value
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == plis_pkg::ST_EMPTY |->
      out_tdata[36:32] == 5'd0 && out_tdata[31:0] == 32'd0 && out_tlast)
    else $error("empty status with nonzero fields");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result word changed under stall");

endmodule

bind positional_list_insert_delete plis_checker #(
  .LIST_CAPACITY (LIST_CAPACITY)
) u_plis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
